// ===== rtl/core/rdi_pkg.sv =====
// Types and constants shared by the ready-to-drive interlock modules.
`timescale 1ns / 1ps

package rdi_pkg;

    localparam int VAL_W = 10;

    // Operating modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE        = 5'b00001,
        MODE_HORN        = 5'b00010,
        MODE_DRIVE       = 5'b00100,
        MODE_TEARDOWN    = 5'b01000,
        MODE_OVERCURRENT = 5'b10000
    } t_mode;

    // Mode codes as reported on the result channel
    localparam logic [2:0] CODE_IDLE        = 3'd0;
    localparam logic [2:0] CODE_HORN        = 3'd1;
    localparam logic [2:0] CODE_DRIVE       = 3'd2;
    localparam logic [2:0] CODE_TEARDOWN    = 3'd3;
    localparam logic [2:0] CODE_OVERCURRENT = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_THR   = 2'd0;
    localparam logic [1:0] CFG_BRAKE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_HORN_TICKS  = 2'd2;
    localparam logic [1:0] CFG_BLINK_TICKS = 2'd3;

    localparam logic [VAL_W-1:0] RST_START_THR   = 10'd184;
    localparam logic [VAL_W-1:0] RST_BRAKE_LIMIT = 10'd400;
    localparam logic [VAL_W-1:0] RST_HORN_TICKS  = 10'd150;
    localparam logic [VAL_W-1:0] RST_BLINK_TICKS = 10'd75;

    typedef struct packed {
        logic [VAL_W-1:0] start_thr;
        logic [VAL_W-1:0] brake_limit;
        logic [VAL_W-1:0] horn_ticks;
        logic [VAL_W-1:0] blink_ticks;
    } t_cfg;

    typedef struct packed {
        logic             button_press;
        logic             brake_pressed;
        logic             loop_open;
        logic             throttle_implausible;
        logic [VAL_W-1:0] pedal_position;
        logic             shutdown_request;
    } t_item;

    // Control state other than the tick counter
    typedef struct packed {
        t_mode mode;
        logic  button_latch;
        logic  shutdown_latch;
        logic  lamp_drive;
        logic  lamp_plaus;
        logic  lamp_fault;
        logic  lamp_active;
        logic  throttle_sel;
        logic  plausible;
        logic  brake_seen;
        logic  horn;
    } t_flags;

    typedef struct packed {
        logic [2:0] mode_code;
        logic       drive_lamp;
        logic       throttle_enable;
        logic       horn_on;
        logic       plausibility_lamp;
        logic       fault_lamp;
        logic       active_lamp;
        logic       throttle_ok;
        logic       brake_flag;
    } t_result;

    function automatic logic [2:0] mode_to_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_HORN:        c = CODE_HORN;
            MODE_DRIVE:       c = CODE_DRIVE;
            MODE_TEARDOWN:    c = CODE_TEARDOWN;
            MODE_OVERCURRENT: c = CODE_OVERCURRENT;
            default:          c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/rdi_cfg_regs.sv =====
// Configuration register bank of the ready-to-drive interlock.
`timescale 1ns / 1ps

module rdi_cfg_regs (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [1:0]              i_cfg_index,
    input  logic [rdi_pkg::VAL_W-1:0] i_cfg_data,
    output logic                    o_cfg_ready,
    output rdi_pkg::t_cfg           o_cfg
);
    import rdi_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_thr   <= RST_START_THR;
            r_cfg.brake_limit <= RST_BRAKE_LIMIT;
            r_cfg.horn_ticks  <= RST_HORN_TICKS;
            r_cfg.blink_ticks <= RST_BLINK_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_THR:   r_cfg.start_thr   <= i_cfg_data;
                CFG_BRAKE_LIMIT: r_cfg.brake_limit <= i_cfg_data;
                CFG_HORN_TICKS:  r_cfg.horn_ticks  <= i_cfg_data;
                CFG_BLINK_TICKS: r_cfg.blink_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/rdi_step.sv =====
// Mode logic: next state and result for one tick.
`timescale 1ns / 1ps

module rdi_step #(
    parameter int COUNT_WIDTH = 11
) (
    input  rdi_pkg::t_cfg          i_cfg,
    input  rdi_pkg::t_item         i_item,
    input  rdi_pkg::t_flags        i_flags,
    input  logic [COUNT_WIDTH-1:0] i_wait,
    output rdi_pkg::t_flags        o_flags,
    output logic [COUNT_WIDTH-1:0] o_wait,
    output rdi_pkg::t_result       o_result
);
    import rdi_pkg::*;

    localparam int LW = ((COUNT_WIDTH > VAL_W) ? COUNT_WIDTH : VAL_W) + 1;
    localparam logic [LW-1:0] CNT_MAX  = LW'((1 << COUNT_WIDTH) - 1);
    localparam logic [LW-1:0] CNT_HALF = CNT_MAX >> 1;

    t_flags                 f;
    logic [COUNT_WIDTH-1:0] w;
    logic [LW-1:0]          horn_ext;
    logic [LW-1:0]          horn_lim;
    logic [LW-1:0]          blink_ext;
    logic [LW-1:0]          blink_lim;
    logic [LW-1:0]          wait_ext;
    logic [COUNT_WIDTH-1:0] wait_inc;
    logic                   blink_end;
    logic                   start_ok;

    assign horn_ext  = LW'(i_cfg.horn_ticks);
    assign horn_lim  = (horn_ext < CNT_MAX) ? horn_ext : CNT_MAX;
    assign blink_ext = LW'(i_cfg.blink_ticks);
    assign blink_lim = (blink_ext < CNT_HALF) ? blink_ext : CNT_HALF;
    assign wait_ext  = LW'(i_wait);
    assign wait_inc  = i_wait + 1'b1;
    assign blink_end = LW'(wait_inc) >= (blink_lim << 1);
    assign start_ok  = i_item.brake_pressed && !i_item.loop_open
                    && !i_item.throttle_implausible
                    && (i_item.pedal_position > i_cfg.start_thr);

    always_comb begin
        f = i_flags;
        w = i_wait;
        if (i_item.button_press)     f.button_latch   = 1'b1;
        if (i_item.shutdown_request) f.shutdown_latch = 1'b1;
        f.lamp_plaus = i_item.throttle_implausible;

        case (i_flags.mode)
            MODE_HORN: begin
                f.plausible    = 1'b0;
                f.throttle_sel = 1'b1;
                if (wait_ext < horn_lim) begin
                    f.horn = 1'b1;
                    w      = wait_inc;
                end else begin
                    f.horn = 1'b0;
                    w      = '0;
                    f.mode = MODE_DRIVE;
                end
            end
            MODE_DRIVE: begin
                w             = '0;
                f.lamp_drive  = 1'b1;
                f.lamp_active = 1'b1;
                f.brake_seen  = i_item.brake_pressed;
                if (i_item.brake_pressed && (i_item.pedal_position > i_cfg.brake_limit))
                    f.mode = MODE_TEARDOWN;
                if (i_item.throttle_implausible)
                    f.mode = MODE_TEARDOWN;
                f.plausible = !i_item.throttle_implausible;
                if (f.shutdown_latch || i_item.loop_open) begin
                    f.mode           = MODE_TEARDOWN;
                    f.shutdown_latch = 1'b0;
                    f.button_latch   = 1'b0;
                end
                if (f.button_latch) begin
                    f.button_latch = 1'b0;
                    f.mode         = MODE_OVERCURRENT;
                end
            end
            MODE_OVERCURRENT: begin
                f.plausible    = 1'b0;
                f.lamp_fault   = 1'b1;
                f.throttle_sel = 1'b0;
                f.lamp_drive   = wait_ext >= blink_lim;
                w              = wait_inc;
                // decisions fall on the last tick of the blink cycle
                if (blink_end) begin
                    w = '0;
                    if (f.button_latch) begin
                        f.button_latch = 1'b0;
                        f.lamp_drive   = 1'b1;
                        f.throttle_sel = 1'b1;
                        f.mode         = MODE_DRIVE;
                    end
                    if (f.shutdown_latch || i_item.loop_open) begin
                        f.mode           = MODE_TEARDOWN;
                        f.shutdown_latch = 1'b0;
                        f.button_latch   = 1'b0;
                    end
                    if (i_item.throttle_implausible)
                        f.mode = MODE_TEARDOWN;
                    f.plausible = !i_item.throttle_implausible;
                end
            end
            MODE_TEARDOWN: begin
                f.mode         = MODE_IDLE;
                w              = '0;
                f.plausible    = 1'b0;
                f.lamp_drive   = 1'b0;
                f.lamp_fault   = 1'b0;
                f.lamp_active  = 1'b0;
                f.throttle_sel = 1'b0;
            end
            default: begin
                f.mode      = MODE_IDLE;
                w           = '0;
                f.plausible = 1'b0;
                if (f.button_latch) begin
                    if (start_ok)
                        f.mode = MODE_HORN;
                    f.button_latch = 1'b0;
                end
            end
        endcase
    end

    assign o_flags = f;
    assign o_wait  = w;

    assign o_result.mode_code         = mode_to_code(i_flags.mode);
    assign o_result.drive_lamp        = f.lamp_drive;
    assign o_result.throttle_enable   = f.throttle_sel;
    assign o_result.horn_on           = f.horn;
    assign o_result.plausibility_lamp = f.lamp_plaus;
    assign o_result.fault_lamp        = f.lamp_fault;
    assign o_result.active_lamp       = f.lamp_active;
    assign o_result.throttle_ok       = f.plausible;
    assign o_result.brake_flag        = f.brake_seen;

endmodule

// ===== rtl/core/ready_to_drive_interlock.sv =====
// Ready-to-drive interlock: input and result registers around the mode logic.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one tick of sampled pins,
//   pedal reading and button / shutdown events per request.
//   Result channel (o_out_valid / i_out_stall) gives one result per tick:
//   mode handled, lamp and output levels after the tick.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the pedal threshold,
//   brake limit, horn length and blink half length; always ready.
//   A request passes through the input register, the mode logic and the result
//   register. Throughput: one tick per cycle while the receiver does not stall,
//   set by the single registered pass through the mode logic.
//   Reset (synchronous, active low) returns to idle with lamps off, latches
//   and counter cleared and the config registers at their defaults; both
//   channels come up empty.
//   While the receiver stalls, the result register holds and one further
//   request is held in the input register; o_in_stall rises after that.
`timescale 1ns / 1ps

module ready_to_drive_interlock #(
    parameter int COUNT_WIDTH = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_valid,
    input  logic [1:0]                i_cfg_index,
    input  logic [rdi_pkg::VAL_W-1:0] i_cfg_data,
    output logic                      o_cfg_ready,
    // tick input
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_button_press,
    input  logic                      i_brake_pressed,
    input  logic                      i_loop_open,
    input  logic                      i_throttle_implausible,
    input  logic [rdi_pkg::VAL_W-1:0] i_pedal_position,
    input  logic                      i_shutdown_request,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [2:0]                o_mode_code,
    output logic                      o_drive_lamp,
    output logic                      o_throttle_enable,
    output logic                      o_horn_on,
    output logic                      o_plausibility_lamp,
    output logic                      o_fault_lamp,
    output logic                      o_active_lamp,
    output logic                      o_throttle_ok,
    output logic                      o_brake_flag
);
    import rdi_pkg::*;

    t_cfg                   cfg;
    logic                   r_in_valid;
    t_item                  r_in;
    logic                   r_out_valid;
    t_result                r_out;
    t_flags                 r_flags;
    logic [COUNT_WIDTH-1:0] r_wait;
    t_flags                 n_flags;
    logic [COUNT_WIDTH-1:0] n_wait;
    t_result                n_out;
    logic                   out_free;
    logic                   take;

    rdi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    rdi_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_cfg    (cfg),
        .i_item   (r_in),
        .i_flags  (r_flags),
        .i_wait   (r_wait),
        .o_flags  (n_flags),
        .o_wait   (n_wait),
        .o_result (n_out)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign take       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in.button_press         <= i_button_press;
            r_in.brake_pressed        <= i_brake_pressed;
            r_in.loop_open            <= i_loop_open;
            r_in.throttle_implausible <= i_throttle_implausible;
            r_in.pedal_position       <= i_pedal_position;
            r_in.shutdown_request     <= i_shutdown_request;
        end
    end

    // mode state, updated once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.mode           <= MODE_IDLE;
            r_flags.button_latch   <= 1'b0;
            r_flags.shutdown_latch <= 1'b0;
            r_flags.lamp_drive     <= 1'b0;
            r_flags.lamp_plaus     <= 1'b0;
            r_flags.lamp_fault     <= 1'b0;
            r_flags.lamp_active    <= 1'b0;
            r_flags.throttle_sel   <= 1'b0;
            r_flags.plausible      <= 1'b0;
            r_flags.brake_seen     <= 1'b0;
            r_flags.horn           <= 1'b0;
            r_wait                 <= '0;
        end else if (take) begin
            r_flags <= n_flags;
            r_wait  <= n_wait;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mode_code         = r_out.mode_code;
    assign o_drive_lamp        = r_out.drive_lamp;
    assign o_throttle_enable   = r_out.throttle_enable;
    assign o_horn_on           = r_out.horn_on;
    assign o_plausibility_lamp = r_out.plausibility_lamp;
    assign o_fault_lamp        = r_out.fault_lamp;
    assign o_active_lamp       = r_out.active_lamp;
    assign o_throttle_ok       = r_out.throttle_ok;
    assign o_brake_flag        = r_out.brake_flag;

endmodule

// ===== dv/ready_to_drive_interlock_test.sv =====
// Self-checking testbench for the ready-to-drive interlock: random ticks against a predictor.
`timescale 1ns / 1ps

module ready_to_drive_interlock_test;

    import rdi_pkg::*;

    localparam int CNT_W = 11;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int STALL_PCT = 28;
    localparam int WATCHDOG_LIMIT = 2000;

    // Predicts the interlock one tick at a time and holds the results still owed.
    class tick_book;
        t_cfg             cfg;
        logic [2:0]       mode;
        logic [CNT_W-1:0] ticks;
        logic             btn_latch, sd_latch;
        logic             lamp_drive, lamp_plaus, lamp_fault, lamp_active;
        logic             thr_sel, plausible, brake_seen, horn;
        t_result          due[$];
        int               errors;

        function new();
            cfg = '{RST_START_THR, RST_BRAKE_LIMIT, RST_HORN_TICKS, RST_BLINK_TICKS};
            mode = CODE_IDLE;
            ticks = '0;
            {btn_latch, sd_latch, lamp_drive, lamp_plaus, lamp_fault, lamp_active} = '0;
            {thr_sel, plausible, brake_seen, horn} = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [VAL_W-1:0] val);
            case (idx)
                CFG_START_THR:   cfg.start_thr = val;
                CFG_BRAKE_LIMIT: cfg.brake_limit = val;
                CFG_HORN_TICKS:  cfg.horn_ticks = val;
                default:         cfg.blink_ticks = val;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_tick(t_item it);
            t_result    r;
            logic [2:0] next;
            int         lim;
            if (it.button_press) btn_latch = 1'b1;
            if (it.shutdown_request) sd_latch = 1'b1;
            lamp_plaus = it.throttle_implausible;
            r.mode_code = mode;
            next = mode;
            case (mode)
                CODE_HORN: begin
                    plausible = 1'b0;
                    thr_sel = 1'b1;
                    lim = (cfg.horn_ticks < CNT_MAX) ? cfg.horn_ticks : CNT_MAX;
                    if (ticks < lim) begin
                        horn = 1'b1;
                        ticks = ticks + 1'b1;
                    end else begin
                        horn = 1'b0;
                        ticks = '0;
                        next = CODE_DRIVE;
                    end
                end
                CODE_DRIVE: begin
                    ticks = '0;
                    lamp_drive = 1'b1;
                    lamp_active = 1'b1;
                    if (it.brake_pressed) begin
                        brake_seen = 1'b1;
                        if (it.pedal_position > cfg.brake_limit) next = CODE_TEARDOWN;
                    end else begin
                        brake_seen = 1'b0;
                    end
                    if (it.throttle_implausible) begin
                        next = CODE_TEARDOWN;
                        plausible = 1'b0;
                    end else begin
                        plausible = 1'b1;
                    end
                    if (sd_latch || it.loop_open) begin
                        next = CODE_TEARDOWN;
                        sd_latch = 1'b0;
                        btn_latch = 1'b0;
                    end
                    // a latched button overrides the brake and plausibility exits
                    if (btn_latch) begin
                        btn_latch = 1'b0;
                        next = CODE_OVERCURRENT;
                    end
                end
                CODE_OVERCURRENT: begin
                    plausible = 1'b0;
                    lamp_fault = 1'b1;
                    thr_sel = 1'b0;
                    lim = (cfg.blink_ticks < CNT_MAX / 2) ? cfg.blink_ticks : CNT_MAX / 2;
                    lamp_drive = (ticks >= lim);
                    ticks = ticks + 1'b1;
                    // end of the blink: later decisions win
                    if (ticks >= 2 * lim) begin
                        ticks = '0;
                        if (btn_latch) begin
                            btn_latch = 1'b0;
                            lamp_drive = 1'b1;
                            thr_sel = 1'b1;
                            next = CODE_DRIVE;
                        end
                        if (sd_latch || it.loop_open) begin
                            next = CODE_TEARDOWN;
                            sd_latch = 1'b0;
                            btn_latch = 1'b0;
                        end
                        if (it.throttle_implausible) begin
                            next = CODE_TEARDOWN;
                            plausible = 1'b0;
                        end else begin
                            plausible = 1'b1;
                        end
                    end
                end
                CODE_TEARDOWN: begin
                    next = CODE_IDLE;
                    ticks = '0;
                    plausible = 1'b0;
                    lamp_drive = 1'b0;
                    lamp_fault = 1'b0;
                    lamp_active = 1'b0;
                    thr_sel = 1'b0;
                end
                default: begin
                    r.mode_code = CODE_IDLE;
                    next = CODE_IDLE;
                    ticks = '0;
                    plausible = 1'b0;
                    if (btn_latch) begin
                        if (it.brake_pressed && !it.loop_open && !it.throttle_implausible &&
                            it.pedal_position > cfg.start_thr)
                            next = CODE_HORN;
                        btn_latch = 1'b0;
                    end
                end
            endcase
            mode = next;
            r.drive_lamp = lamp_drive;
            r.throttle_enable = thr_sel;
            r.horn_on = horn;
            r.plausibility_lamp = lamp_plaus;
            r.fault_lamp = lamp_fault;
            r.active_lamp = lamp_active;
            r.throttle_ok = plausible;
            r.brake_flag = brake_seen;
            due.push_back(r);
        endfunction

        function void compare(string name, logic [2:0] want, logic [2:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check(t_result got);
            t_result want;
            if (due.size() == 0) begin
                $error("unexpected result: mode_code %0d", got.mode_code);
                errors++;
                return;
            end
            want = due.pop_front();
            compare("mode_code", want.mode_code, got.mode_code);
            compare("drive_lamp", want.drive_lamp, got.drive_lamp);
            compare("throttle_enable", want.throttle_enable, got.throttle_enable);
            compare("horn_on", want.horn_on, got.horn_on);
            compare("plausibility_lamp", want.plausibility_lamp, got.plausibility_lamp);
            compare("fault_lamp", want.fault_lamp, got.fault_lamp);
            compare("active_lamp", want.active_lamp, got.active_lamp);
            compare("throttle_ok", want.throttle_ok, got.throttle_ok);
            compare("brake_flag", want.brake_flag, got.brake_flag);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [1:0]       i_cfg_index = CFG_START_THR;
    logic [VAL_W-1:0] i_cfg_data = '0;
    logic             o_cfg_ready;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_button_press = 1'b0;
    logic             i_brake_pressed = 1'b0;
    logic             i_loop_open = 1'b0;
    logic             i_throttle_implausible = 1'b0;
    logic [VAL_W-1:0] i_pedal_position = '0;
    logic             i_shutdown_request = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [2:0]       o_mode_code;
    logic             o_drive_lamp, o_throttle_enable, o_horn_on, o_plausibility_lamp;
    logic             o_fault_lamp, o_active_lamp, o_throttle_ok, o_brake_flag;

    tick_book book = new();
    bit       steady = 1'b0;

    ready_to_drive_interlock #(
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .o_cfg_ready            (o_cfg_ready),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_button_press         (i_button_press),
        .i_brake_pressed        (i_brake_pressed),
        .i_loop_open            (i_loop_open),
        .i_throttle_implausible (i_throttle_implausible),
        .i_pedal_position       (i_pedal_position),
        .i_shutdown_request     (i_shutdown_request),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_mode_code            (o_mode_code),
        .o_drive_lamp           (o_drive_lamp),
        .o_throttle_enable      (o_throttle_enable),
        .o_horn_on              (o_horn_on),
        .o_plausibility_lamp    (o_plausibility_lamp),
        .o_fault_lamp           (o_fault_lamp),
        .o_active_lamp          (o_active_lamp),
        .o_throttle_ok          (o_throttle_ok),
        .o_brake_flag           (o_brake_flag)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < STALL_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            book.check('{o_mode_code, o_drive_lamp, o_throttle_enable, o_horn_on,
                         o_plausibility_lamp, o_fault_lamp, o_active_lamp,
                         o_throttle_ok, o_brake_flag});
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_item mk(bit b, bit br, bit lo, bit im, logic [VAL_W-1:0] pd, bit sd);
        t_item it;
        it = '{b, br, lo, im, pd, sd};
        return it;
    endfunction

    // Mostly well-formed ticks steered by the predicted mode, some pure noise.
    function automatic t_item make_tick();
        t_item       it;
        logic [14:0] raw;
        if ($urandom_range(0, 99) < 15) begin
            raw = 15'($urandom);
            it = raw;
            return it;
        end
        it.button_press = $urandom_range(0, 99) < ((book.mode == CODE_IDLE) ? 40 : 4);
        it.brake_pressed = (book.mode == CODE_IDLE) ? ($urandom_range(0, 3) != 0)
                                                    : 1'($urandom_range(0, 1));
        it.loop_open = $urandom_range(0, 99) < 3;
        it.throttle_implausible = $urandom_range(0, 99) < 4;
        it.shutdown_request = $urandom_range(0, 99) < 3;
        if (book.mode == CODE_IDLE && $urandom_range(0, 9) != 0)
            it.pedal_position = (book.cfg.start_thr == '1) ? '1
                                : VAL_W'($urandom_range(book.cfg.start_thr + 1, 1023));
        else if (it.brake_pressed && $urandom_range(0, 9) != 0)
            it.pedal_position = VAL_W'($urandom_range(0, book.cfg.brake_limit));
        else
            it.pedal_position = VAL_W'($urandom);
        return it;
    endfunction

    // No button, shutdown, loop or plausibility events; brake and pedal are random
    function automatic t_item calm_tick();
        return mk(1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'b0, VAL_W'($urandom), 1'b0);
    endfunction

    // Steers towards drive from any mode: start from idle, button in overcurrent
    function automatic t_item walk_tick();
        t_item it;
        case (book.mode)
            CODE_IDLE:        it = mk(1'b1, 1'b1, 1'b0, 1'b0, '1, 1'b0);
            CODE_OVERCURRENT: it = mk(1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            default:          it = calm_tick();
        endcase
        return it;
    endfunction

    task automatic send_tick(input t_item it);
        while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_button_press <= it.button_press;
        i_brake_pressed <= it.brake_pressed;
        i_loop_open <= it.loop_open;
        i_throttle_implausible <= it.throttle_implausible;
        i_pedal_position <= it.pedal_position;
        i_shutdown_request <= it.shutdown_request;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        book.note_tick(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input t_cfg c);
        logic [1:0]       idx[4];
        logic [VAL_W-1:0] val[4];
        idx = '{CFG_START_THR, CFG_BRAKE_LIMIT, CFG_HORN_TICKS, CFG_BLINK_TICKS};
        val = '{c.start_thr, c.brake_limit, c.horn_ticks, c.blink_ticks};
        foreach (idx[k]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            book.set_reg(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n, input bit hold_off);
        for (int k = 0; k < n; k++) begin
            if (hold_off && k == n / 2) drain();
            send_tick(make_tick());
        end
        drain();
    endtask

    initial begin
        t_item plan[$];
        t_cfg  c;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short horn and blink so the directed walk reaches every mode
        set_config('{RST_START_THR, RST_BRAKE_LIMIT, 10'd2, 10'd2});
        plan = '{mk(0, 0, 0, 0, 0, 0),
                 mk(1, 1, 1, 0, 185, 0),      // loop open blocks start
                 mk(1, 1, 0, 1, 185, 0),      // implausible throttle blocks start
                 mk(1, 1, 0, 0, 184, 0),      // pedal at threshold only
                 mk(1, 0, 0, 0, 1023, 0),     // no brake
                 mk(1, 1, 1, 1, 1023, 1),     // shutdown in idle stays latched
                 mk(1, 1, 0, 0, 1023, 0),
                 mk(0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0),
                 mk(0, 1, 0, 0, 10, 0),       // latched shutdown ends drive
                 mk(0, 0, 0, 0, 0, 0),
                 mk(1, 1, 0, 0, 185, 0),
                 mk(0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0),
                 mk(1, 1, 0, 0, 401, 0),      // brake exit, but button wins
                 mk(1, 0, 0, 0, 0, 0),
                 mk(0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0),
                 mk(0, 0, 0, 1, 0, 0),        // blink end: implausible beats button
                 mk(0, 0, 0, 0, 0, 0),
                 mk(0, 1, 0, 0, 0, 0)};
        foreach (plan[k]) send_tick(plan[k]);
        drain();

        set_config('{RST_START_THR, RST_BRAKE_LIMIT, RST_HORN_TICKS, RST_BLINK_TICKS});
        run_random(250, 1'b0);

        steady = 1'b1;
        set_config('{10'd0, 10'd0, 10'd1, 10'd1});
        run_random(250, 1'b0);
        steady = 1'b0;

        set_config('{10'd1023, 10'd1023, 10'd3, 10'd2});
        run_random(100, 1'b0);

        repeat (3) begin
            c.start_thr = VAL_W'($urandom_range(0, 600));
            c.brake_limit = VAL_W'($urandom_range(150, 1023));
            c.horn_ticks = VAL_W'($urandom_range(1, 12));
            c.blink_ticks = VAL_W'($urandom_range(1, 12));
            set_config(c);
            run_random(150, 1'b1);
        end

        // long horn and blink, walked through once
        set_config('{10'd0, 10'd1023, 10'd300, 10'd150});
        while (book.mode != CODE_DRIVE) send_tick(walk_tick());
        send_tick(mk(1, 0, 0, 0, 0, 0));
        while (book.mode != CODE_DRIVE) send_tick(walk_tick());
        send_tick(mk(0, 0, 0, 0, 0, 1));
        send_tick(calm_tick());

        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
